>>> hdl/tknt_pkg.sv
package tknt_pkg;

  localparam int CNT_W     = 7;
  localparam int ID_W      = 31;
  localparam int DIST_W    = 32;
  localparam int OID_W     = 32;
  localparam int ST_W      = 3;
  localparam int CMD_W     = 2;
  localparam int MAX_K_DEF = 64;

  localparam logic [CNT_W-1:0] K_RESET = 7'd16;

  localparam logic [CMD_W-1:0] CMD_RESET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd3;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_PRUNED    = 3'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [ST_W-1:0] ST_QUERY     = 3'd3;
  localparam logic [ST_W-1:0] ST_EXTRACT   = 3'd4;
  localparam logic [ST_W-1:0] ST_RESET     = 3'd5;

  // read address select for the slot stores
  localparam logic [1:0] RD_KM1   = 2'd0;
  localparam logic [1:0] RD_IDX   = 2'd1;
  localparam logic [1:0] RD_IDXM1 = 2'd2;

  typedef struct packed {
    logic            load;
    logic            rd;
    logic [1:0]      rd_sel;
    logic            scan_step;
    logic            shift_init;
    logic            shift_wr;
    logic            ins_wr;
    logic            ex_next;
    logic            emit;
    logic [ST_W-1:0] emit_st;
    logic            fill_clr;
    logic            fill_keep;
  } tknt_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             scan_last;
    logic             pruned;
    logic             hit;
    logic             shift_more;
    logic             ex_last;
  } tknt_sts_t;

endpackage

>>> hdl/top_k_nearest_tracker_unit.sv
// Channel   Handshake              Word
// input     start / busy           in_command, in_frame_id, in_distance
// result    out_strobe (1 cycle)   out_status, out_found, out_id, out_distance,
//                                  out_entry_valid, out_last, out_held_count
// config    cfg_valid / cfg_ready  cfg_k_neighbors
//
// One command at a time; busy drops in the cycle that shows its last result word.
// The slot stores have one read and one write port, so scan and shift visit each
// slot in a read state followed by a compare state (scan) or a write state (shift).
// Reset (rst_n low, synchronous) empties the list and sets k to 16; the slot
// stores themselves are not cleared, only slots below the held count reach a result word.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module top_k_nearest_tracker_unit
  import tknt_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // command input
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [ID_W-1:0]          in_frame_id,
  input  logic [DIST_W-1:0]        in_distance,
  // result words
  output logic                     out_strobe,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_found,
  output logic signed [OID_W-1:0]  out_id,
  output logic [DIST_W-1:0]        out_distance,
  output logic                     out_entry_valid,
  output logic                     out_last,
  output logic [CNT_W-1:0]         out_held_count,
  // k register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_k_neighbors
);

  tknt_ctl_t ctl;
  tknt_sts_t sts;
  logic      cfg_we;

  // k is only taken between commands, never beside a command being accepted
  assign cfg_ready = ~busy & ~start;
  assign cfg_we    = cfg_valid & cfg_ready;

  tknt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  tknt_datapath #(
    .MAX_K (MAX_K)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_k           (cfg_k_neighbors),
    .in_command      (in_command),
    .in_frame_id     (in_frame_id),
    .in_distance     (in_distance),
    .ctl             (ctl),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_id          (out_id),
    .out_distance    (out_distance),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last),
    .out_held_count  (out_held_count)
  );

endmodule

>>> hdl/tknt_datapath.sv
module tknt_datapath
  import tknt_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_k,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [ID_W-1:0]          in_frame_id,
  input  logic [DIST_W-1:0]        in_distance,
  input  tknt_ctl_t                ctl,
  output tknt_sts_t                sts,
  output logic                     out_strobe,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_found,
  output logic signed [OID_W-1:0]  out_id,
  output logic [DIST_W-1:0]        out_distance,
  output logic                     out_entry_valid,
  output logic                     out_last,
  output logic [CNT_W-1:0]         out_held_count
);

  localparam int AW = $clog2(MAX_K);

  logic [DIST_W-1:0] dist_mem [MAX_K];
  logic [ID_W-1:0]   id_mem   [MAX_K];

  logic [CNT_W-1:0]  k_r, fill_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r, rd_id_r;
  logic [DIST_W-1:0] dist_r, rd_dist_r;
  logic [CNT_W-1:0]  keff_r, n_r, idx_r, pos_r;
  logic              pos_found_r, hit_r;

  logic [CNT_W-1:0]  k_one, keff, n_eff, new_n, shift_top;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              mem_we, ex_real, is_ex;
  logic [DIST_W-1:0] wr_dist;
  logic [ID_W-1:0]   wr_id;

  // effective k: zero reads as one, clamp to the store depth
  assign k_one = (k_r == '0) ? CNT_W'(1) : k_r;
  assign keff  = (int'(k_one) > MAX_K) ? CNT_W'(MAX_K) : k_one;
  assign n_eff = (fill_r < keff) ? fill_r : keff;

  assign new_n     = (n_r < keff_r) ? n_r + CNT_W'(1) : n_r;
  assign shift_top = (n_r < keff_r) ? n_r : keff_r - CNT_W'(1);
  assign ex_real   = idx_r < n_r;
  assign is_ex     = ctl.emit_st == ST_EXTRACT;

  always_comb begin
    unique case (ctl.rd_sel)
      RD_KM1:   rd_addr = AW'(keff_r - CNT_W'(1));
      RD_IDX:   rd_addr = AW'(idx_r);
      RD_IDXM1: rd_addr = AW'(idx_r - CNT_W'(1));
      default:  rd_addr = AW'(idx_r);
    endcase
  end

  assign mem_we  = ctl.shift_wr | ctl.ins_wr;
  assign wr_addr = ctl.shift_wr ? AW'(idx_r) : AW'(pos_r);
  assign wr_dist = ctl.shift_wr ? rd_dist_r : dist_r;
  assign wr_id   = ctl.shift_wr ? rd_id_r : id_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dist_mem[wr_addr] <= wr_dist;
      id_mem[wr_addr]   <= wr_id;
    end
    if (ctl.rd) begin
      rd_dist_r <= dist_mem[rd_addr];
      rd_id_r   <= id_mem[rd_addr];
    end
  end

  // config register and held count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= K_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) k_r <= cfg_k;
      if (ctl.fill_clr)       fill_r <= '0;
      else if (ctl.fill_keep) fill_r <= n_r;
      else if (ctl.ins_wr)    fill_r <= new_n;
    end
  end

  // per-command working registers, loaded before use
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r       <= in_command;
      id_r        <= in_frame_id;
      dist_r      <= in_distance;
      keff_r      <= keff;
      n_r         <= n_eff;
      idx_r       <= '0;
      pos_r       <= n_eff;
      pos_found_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (ctl.scan_step) begin
        hit_r <= hit_r | (rd_id_r == id_r);
        if (!pos_found_r && (dist_r < rd_dist_r)) begin
          pos_r       <= idx_r;
          pos_found_r <= 1'b1;
        end
      end
      if (ctl.scan_step || ctl.ex_next) idx_r <= idx_r + CNT_W'(1);
      else if (ctl.shift_init)          idx_r <= shift_top;
      else if (ctl.shift_wr)            idx_r <= idx_r - CNT_W'(1);
    end
  end

  assign sts.cmd        = cmd_r;
  assign sts.full       = n_r >= keff_r;
  assign sts.empty      = n_r == '0;
  assign sts.scan_last  = idx_r == (n_r - CNT_W'(1));
  assign sts.pruned     = dist_r >= rd_dist_r;
  assign sts.hit        = hit_r;
  assign sts.shift_more = idx_r > pos_r;
  assign sts.ex_last    = idx_r == (keff_r - CNT_W'(1));

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= ctl.emit;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status      <= ctl.emit_st;
      out_found       <= (ctl.emit_st == ST_QUERY) & hit_r;
      out_entry_valid <= is_ex & ex_real;
      out_last        <= ~is_ex | sts.ex_last;
      if (is_ex && ex_real) begin
        out_id       <= {1'b0, rd_id_r};
        out_distance <= rd_dist_r;
      end else if (is_ex) begin
        out_id       <= '1;
        out_distance <= '0;
      end else begin
        out_id       <= '0;
        out_distance <= '0;
      end
      if (ctl.emit_st == ST_INSERTED)   out_held_count <= new_n;
      else if (ctl.emit_st == ST_RESET) out_held_count <= '0;
      else                              out_held_count <= n_r;
    end
  end

endmodule

>>> hdl/tknt_ctrl.sv
module tknt_ctrl
  import tknt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tknt_sts_t sts,
  output tknt_ctl_t ctl
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_PR_RD   = 4'd2;
  localparam logic [3:0] S_PR_CMP  = 4'd3;
  localparam logic [3:0] S_SC_RD   = 4'd4;
  localparam logic [3:0] S_SC_CMP  = 4'd5;
  localparam logic [3:0] S_SC_END  = 4'd6;
  localparam logic [3:0] S_SH_INIT = 4'd7;
  localparam logic [3:0] S_SH_RD   = 4'd8;
  localparam logic [3:0] S_SH_WR   = 4'd9;
  localparam logic [3:0] S_EX_RD   = 4'd10;
  localparam logic [3:0] S_EX_EMIT = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = state_r != S_IDLE;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.cmd)
          CMD_RESET: begin
            ctl.emit     = 1'b1;
            ctl.emit_st  = ST_RESET;
            ctl.fill_clr = 1'b1;
            state_nxt    = S_IDLE;
          end
          CMD_QUERY: begin
            if (sts.empty) begin
              ctl.emit    = 1'b1;
              ctl.emit_st = ST_QUERY;
              state_nxt   = S_IDLE;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
          CMD_PUSH: begin
            if (sts.full)       state_nxt = S_PR_RD;
            else if (sts.empty) state_nxt = S_SH_INIT;
            else                state_nxt = S_SC_RD;
          end
          CMD_EXTRACT: state_nxt = S_EX_RD;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_PR_RD: begin
        ctl.rd     = 1'b1;
        ctl.rd_sel = RD_KM1;
        state_nxt  = S_PR_CMP;
      end
      S_PR_CMP: begin
        if (sts.pruned) begin
          ctl.emit      = 1'b1;
          ctl.emit_st   = ST_PRUNED;
          ctl.fill_keep = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        ctl.rd     = 1'b1;
        ctl.rd_sel = RD_IDX;
        state_nxt  = S_SC_CMP;
      end
      S_SC_CMP: begin
        ctl.scan_step = 1'b1;
        state_nxt     = sts.scan_last ? S_SC_END : S_SC_RD;
      end
      S_SC_END: begin
        if (sts.cmd == CMD_QUERY) begin
          ctl.emit    = 1'b1;
          ctl.emit_st = ST_QUERY;
          state_nxt   = S_IDLE;
        end else if (sts.hit) begin
          ctl.emit      = 1'b1;
          ctl.emit_st   = ST_DUPLICATE;
          ctl.fill_keep = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SH_INIT;
        end
      end
      S_SH_INIT: begin
        ctl.shift_init = 1'b1;
        state_nxt      = S_SH_RD;
      end
      S_SH_RD: begin
        if (sts.shift_more) begin
          ctl.rd     = 1'b1;
          ctl.rd_sel = RD_IDXM1;
          state_nxt  = S_SH_WR;
        end else begin
          ctl.ins_wr  = 1'b1;
          ctl.emit    = 1'b1;
          ctl.emit_st = ST_INSERTED;
          state_nxt   = S_IDLE;
        end
      end
      S_SH_WR: begin
        ctl.shift_wr = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_EX_RD: begin
        ctl.rd     = 1'b1;
        ctl.rd_sel = RD_IDX;
        state_nxt  = S_EX_EMIT;
      end
      S_EX_EMIT: begin
        ctl.emit    = 1'b1;
        ctl.emit_st = ST_EXTRACT;
        ctl.ex_next = 1'b1;
        state_nxt   = sts.ex_last ? S_IDLE : S_EX_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> tb/sv/knn_list_checker.sv
module knn_list_checker
  import tknt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [ID_W-1:0]          in_frame_id,
  input  logic [DIST_W-1:0]        in_distance,
  input  logic                     out_strobe,
  input  logic [ST_W-1:0]          out_status,
  input  logic                     out_found,
  input  logic signed [OID_W-1:0]  out_id,
  input  logic [DIST_W-1:0]        out_distance,
  input  logic                     out_entry_valid,
  input  logic                     out_last,
  input  logic [CNT_W-1:0]         out_held_count,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_k_neighbors,
  output int                       fail_count,
  output int                       pending,
  output int                       words_checked
);

  localparam int SLOTS = MAX_K_DEF;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              found;
    logic [OID_W-1:0]  oid;
    logic [DIST_W-1:0] dkey;
    logic              valid;
    logic              last;
    logic [CNT_W-1:0]  held;
  } knn_word_t;

  knn_word_t         expected_words [$];
  logic [DIST_W-1:0] dist_slot [SLOTS];
  logic [ID_W-1:0]   id_slot [SLOTS];
  logic [CNT_W-1:0]  fill_reg;
  logic [CNT_W-1:0]  k_reg;

  initial begin
    fail_count    = 0;
    pending       = 0;
    words_checked = 0;
    fill_reg      = '0;
    k_reg         = K_RESET;
    foreach (dist_slot[i]) begin
      dist_slot[i] = '0;
      id_slot[i]   = '0;
    end
  end

  function automatic int unsigned k_eff();
    int unsigned k;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > SLOTS) k = SLOTS;
    return k;
  endfunction

  function automatic logic id_held(input logic [ID_W-1:0] id, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (id_slot[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic knn_word_t make_word(input logic [ST_W-1:0] st, input logic fnd,
                                          input logic [OID_W-1:0] oid,
                                          input logic [DIST_W-1:0] d, input logic v,
                                          input logic lst, input int unsigned held);
    knn_word_t w;
    w.status = st;
    w.found  = fnd;
    w.oid    = oid;
    w.dkey   = d;
    w.valid  = v;
    w.last   = lst;
    w.held   = held[CNT_W-1:0];
    return w;
  endfunction

  // list update and expected words for one accepted command
  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                 input logic [DIST_W-1:0] d);
    int unsigned k;
    int unsigned n;
    int unsigned pos;
    k = k_eff();
    n = (fill_reg < k) ? fill_reg : k;
    case (cmd)
      CMD_RESET: begin
        fill_reg = '0;
        expected_words.push_back(make_word(ST_RESET, 1'b0, '0, '0, 1'b0, 1'b1, 0));
      end
      CMD_QUERY: begin
        expected_words.push_back(make_word(ST_QUERY, id_held(id, n), '0, '0, 1'b0, 1'b1, n));
      end
      CMD_EXTRACT: begin
        for (int unsigned i = 0; i < k; i++) begin
          if (i < n)
            expected_words.push_back(make_word(ST_EXTRACT, 1'b0, {1'b0, id_slot[i]},
                                               dist_slot[i], 1'b1, i + 1 == k, n));
          else
            expected_words.push_back(make_word(ST_EXTRACT, 1'b0, '1, '0, 1'b0,
                                               i + 1 == k, n));
        end
      end
      CMD_PUSH: begin
        // threshold prune wins over the duplicate check
        if (n >= k && d >= dist_slot[k-1]) begin
          fill_reg = n[CNT_W-1:0];
          expected_words.push_back(make_word(ST_PRUNED, 1'b0, '0, '0, 1'b0, 1'b1, n));
        end else if (id_held(id, n)) begin
          fill_reg = n[CNT_W-1:0];
          expected_words.push_back(make_word(ST_DUPLICATE, 1'b0, '0, '0, 1'b0, 1'b1, n));
        end else begin
          pos = n;
          for (int unsigned i = 0; i < n; i++) begin
            if (d < dist_slot[i]) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = k - 1; i > pos; i--) begin
            dist_slot[i] = dist_slot[i-1];
            id_slot[i]   = id_slot[i-1];
          end
          dist_slot[pos] = d;
          id_slot[pos]   = id;
          if (n < k) n++;
          fill_reg = n[CNT_W-1:0];
          expected_words.push_back(make_word(ST_INSERTED, 1'b0, '0, '0, 1'b0, 1'b1, n));
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_word(input knn_word_t got);
    knn_word_t want;
    if (expected_words.size() == 0) begin
      $error("result word with status %0d but nothing expected", got.status);
      fail_count++;
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (got.status !== want.status) begin
      $error("out_status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.found !== want.found) begin
      $error("out_found: expected %0d, got %0d", want.found, got.found);
      fail_count++;
    end
    if (got.oid !== want.oid) begin
      $error("out_id: expected %0d, got %0d", $signed(want.oid), $signed(got.oid));
      fail_count++;
    end
    if (got.dkey !== want.dkey) begin
      $error("out_distance: expected %0d, got %0d", want.dkey, got.dkey);
      fail_count++;
    end
    if (got.valid !== want.valid) begin
      $error("out_entry_valid: expected %0d, got %0d", want.valid, got.valid);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("out_last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
    if (got.held !== want.held) begin
      $error("out_held_count: expected %0d, got %0d", want.held, got.held);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      fill_reg = '0;
      k_reg    = K_RESET;
    end else begin
      if (cfg_valid && cfg_ready) k_reg = cfg_k_neighbors;
      if (start && !busy) predict_command(in_command, in_frame_id, in_distance);
      if (out_strobe)
        compare_word({out_status, out_found, out_id, out_distance, out_entry_valid,
                      out_last, out_held_count});
    end
    pending = expected_words.size();
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  import tknt_pkg::*;

  // Longest legal quiet stretch is a push into a full 64-slot list plus a sender
  // gap; this leaves plenty of headroom.
  localparam int WATCHDOG_LIMIT = 4000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_command = CMD_QUERY;
  logic [ID_W-1:0]          in_frame_id = '0;
  logic [DIST_W-1:0]        in_distance = '0;
  logic                     out_strobe;
  logic [ST_W-1:0]          out_status;
  logic                     out_found;
  logic signed [OID_W-1:0]  out_id;
  logic [DIST_W-1:0]        out_distance;
  logic                     out_entry_valid;
  logic                     out_last;
  logic [CNT_W-1:0]         out_held_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_k_neighbors = K_RESET;

  int fail_count;
  int pending;
  int words_checked;

  // run statistics for the closing summary
  int n_push = 0;
  int n_query = 0;
  int n_extract = 0;
  int n_clear = 0;
  int n_settings = 0;

  int gap_pct = 0;       // chance (per cent) of an idle gap before each command word
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  top_k_nearest_tracker_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_frame_id     (in_frame_id),
    .in_distance     (in_distance),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_id          (out_id),
    .out_distance    (out_distance),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last),
    .out_held_count  (out_held_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_k_neighbors (cfg_k_neighbors)
  );

  // Checker sits beside the block: watches all three channels, keeps its own
  // copy of the list and compares every result word.
  knn_list_checker list_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_frame_id     (in_frame_id),
    .in_distance     (in_distance),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_id          (out_id),
    .out_distance    (out_distance),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last),
    .out_held_count  (out_held_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_k_neighbors (cfg_k_neighbors),
    .fail_count      (fail_count),
    .pending         (pending),
    .words_checked   (words_checked)
  );

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Idle mix per phase: none, heavy, none, moderate.
  function automatic int idle_pct(input int p);
    case (p % 4)
      1:       return 53;
      3:       return 34;
      default: return 0;
    endcase
  endfunction

  // k per random phase; covers 0 (read as 1), 1, 64 and 127 (read as 64)
  function automatic logic [CNT_W-1:0] k_for_phase(input int p);
    case (p)
      0:       return 7'd16;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd0;
      4:       return 7'd127;
      5:       return 7'd2;
      6:       return 7'd5;
      7:       return 7'd8;
      8:       return 7'd33;
      9:       return 7'd100;
      10:      return 7'd3;
      default: return 7'd12;
    endcase
  endfunction

  // Called just after a falling edge. Start is left high after acceptance so
  // back-to-back words need no idle gap; a gap drops it first.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [DIST_W-1:0] d);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start       = 1'b1;
    in_command  = cmd;
    in_frame_id = id;
    in_distance = d;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (cmd)
      CMD_RESET:   n_clear++;
      CMD_PUSH:    n_push++;
      CMD_QUERY:   n_query++;
      CMD_EXTRACT: n_extract++;
      default: ;
    endcase
  endtask

  // Sender pauses until every expected word has come and the block is idle.
  task automatic settle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only ever called from an idle block (after settle).
  task automatic write_k(input logic [CNT_W-1:0] k);
    cfg_valid       = 1'b1;
    cfg_k_neighbors = k;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [ID_W-1:0]   id_base;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] d;
    logic [CMD_W-1:0]  cmd;
    logic [31:0]       rnd;
    int unsigned       pick;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed: reset value of k (16) ---
    send_word(CMD_EXTRACT, '0, '0);                    // empty list, all slots padded
    send_word(CMD_QUERY, '0, '0);                      // query on empty list
    send_word(CMD_PUSH, 31'd5, 32'd100);
    send_word(CMD_PUSH, '1, '1);                       // largest id and distance
    send_word(CMD_PUSH, '0, '0);                       // smallest id and distance
    send_word(CMD_PUSH, 31'd9, 32'd100);               // tie: goes after id 5
    send_word(CMD_PUSH, 31'd5, 32'd50);                // id already held
    send_word(CMD_QUERY, '1, '0);                      // present
    send_word(CMD_QUERY, 31'd12345, '1);               // absent
    send_word(CMD_EXTRACT, '0, '0);

    // --- k shrunk to 3 without a list reset: only first three slots count ---
    settle();
    write_k(7'd3);
    send_word(CMD_QUERY, '1, '0);                      // now beyond the held count
    send_word(CMD_PUSH, 31'd77, 32'd100);              // full, equal to k-th: pruned
    send_word(CMD_PUSH, 31'd5, 32'd200);               // prune checked before duplicate
    send_word(CMD_PUSH, 31'd5, 32'd99);                // below k-th but held: duplicate
    send_word(CMD_PUSH, 31'd42, 32'd1);                // insert mid-list, last slot drops
    send_word(CMD_EXTRACT, '0, '0);

    // --- k of 0 is read as 1 ---
    settle();
    write_k(7'd0);
    send_word(CMD_PUSH, 31'd3, 32'd0);                 // full at one entry, tie: pruned
    send_word(CMD_EXTRACT, '0, '0);
    send_word(CMD_RESET, '1, '1);
    send_word(CMD_EXTRACT, '0, '0);

    // --- k above the maximum is read as 64 ---
    settle();
    write_k(7'd127);
    send_word(CMD_PUSH, '0, '1);
    send_word(CMD_EXTRACT, '0, '0);
    send_word(CMD_RESET, '0, '0);

    // --- random phases: mostly pushes from a small id pool, so duplicates,
    //     prunes and hits on query are common; ties come from narrow distances ---
    for (int p = 0; p < 12; p++) begin
      settle();
      gap_pct = idle_pct(p);
      write_k(k_for_phase(p));
      rnd     = $urandom();
      id_base = rnd[ID_W-1:0];
      // about half the phases keep the old list across the k change
      if ($urandom_range(1) == 1) begin
        rnd = $urandom();
        send_word(CMD_RESET, rnd[ID_W-1:0], $urandom());
      end
      repeat (17) begin
        pick = $urandom_range(99);
        if (pick < 3)       cmd = CMD_RESET;
        else if (pick < 10) cmd = CMD_EXTRACT;
        else if (pick < 28) cmd = CMD_QUERY;
        else                cmd = CMD_PUSH;
        if ($urandom_range(9) < 8) begin
          rnd = $urandom_range(15);
          id  = id_base + rnd[ID_W-1:0];
        end else begin
          rnd = $urandom();
          id  = rnd[ID_W-1:0];
        end
        pick = $urandom_range(9);
        if (pick < 5)       d = $urandom_range(40);
        else if (pick < 8)  d = $urandom();
        else if (pick == 8) d = '0;
        else                d = '1;
        send_word(cmd, id, d);
      end
    end

    settle();
    $display("Covered %0d pushes, %0d queries, %0d extracts and %0d list resets",
             n_push, n_query, n_extract, n_clear);
    $display("over %0d k settings with mixed idle gaps; %0d result words compared",
             n_settings, words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
